>>> sv/uft_pkg.sv
package uft_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 16;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Event kinds
    localparam logic [1:0] FN_BUS_READ  = 2'd0;
    localparam logic [1:0] FN_BUS_WRITE = 2'd1;
    localparam logic [1:0] FN_LINE_RX   = 2'd2;
    localparam logic [1:0] FN_TX_DRAIN  = 2'd3;

    // Register selects
    localparam logic [1:0] REG_RX_DATA = 2'd0;
    localparam logic [1:0] REG_TX_DATA = 2'd1;
    localparam logic [1:0] REG_STATUS  = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    // Status word bits
    localparam logic [31:0] ST_TX_FULL  = 32'h0000_0008;
    localparam logic [31:0] ST_TX_EMPTY = 32'h0000_0004;
    localparam logic [31:0] ST_RX_FULL  = 32'h0000_0002;
    localparam logic [31:0] ST_RX_VALID = 32'h0000_0001;

    // Control word bits
    localparam int CTL_FLUSH_TX = 0;
    localparam int CTL_FLUSH_RX = 1;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  reg_sel;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } uft_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        tx_pending;
        logic        irq;
    } uft_res_t;

    // FIFO commands from the register logic
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } uft_fifo_ctrl_t;

    // FIFO status back to the register logic
    typedef struct packed {
        logic       empty;
        logic       full;
        logic       one_left;
        logic       empty_after;
    } uft_fifo_stat_t;

endpackage

>>> sv/uart_fifo_register_device.sv
// UART register block with a receive and a transmit FIFO. One request (bus read,
// bus write, line byte or transmit drain) is taken per clock and its result is
// shown in the next cycle from the output register, so the sustained rate is one
// request per cycle while m_ready stays high. Each FIFO is a chain of byte cells
// that shift toward the head on a pop, with a fill counter choosing the cell a
// push loads; each request completes in the cycle it is taken. Pushes into a full
// FIFO are dropped, and an empty receive-data read returns the last byte held.
module uart_fifo_register_device (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uft_pkg::uft_req_t s_req,
    output logic              m_valid,
    input  logic              m_ready,
    output uft_pkg::uft_res_t m_res
);
    import uft_pkg::*;

    logic           fire;
    logic           is_read;
    logic           is_write;
    uft_fifo_ctrl_t rx_ctrl;
    uft_fifo_ctrl_t tx_ctrl;
    uft_fifo_stat_t rx_stat;
    uft_fifo_stat_t tx_stat;
    logic [7:0]     rx_head_byte;
    logic [7:0]     tx_head_byte;

    logic [7:0]  rx_hold_reg, rx_hold_next;
    logic [31:0] tx_hold_reg, tx_hold_next;
    logic [31:0] control_word_reg, control_word_next;
    logic        ack_wait_reg, ack_wait_next;
    logic        m_valid_reg, m_valid_next;
    uft_res_t    m_res_reg, m_res_next;
    logic [31:0] status_word;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    assign is_read  = fire && (s_req.func == FN_BUS_READ);
    assign is_write = fire && (s_req.func == FN_BUS_WRITE);

    // FIFO commands
    assign rx_ctrl.push  = fire && (s_req.func == FN_LINE_RX);
    assign rx_ctrl.pop   = is_read && (s_req.reg_sel == REG_RX_DATA) && !rx_stat.empty;
    assign rx_ctrl.flush = is_write && (s_req.reg_sel == REG_CONTROL)
                           && s_req.write_data[CTL_FLUSH_RX];
    assign tx_ctrl.push  = is_write && (s_req.reg_sel == REG_TX_DATA);
    assign tx_ctrl.pop   = fire && (s_req.func == FN_TX_DRAIN) && !tx_stat.empty;
    assign tx_ctrl.flush = is_write && (s_req.reg_sel == REG_CONTROL)
                           && s_req.write_data[CTL_FLUSH_TX];

    uft_fifo u_rx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (rx_ctrl),
        .din       (s_req.rx_byte),
        .head_byte (rx_head_byte),
        .stat      (rx_stat)
    );

    uft_fifo u_tx_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (tx_ctrl),
        .din       (s_req.write_data[7:0]),
        .head_byte (tx_head_byte),
        .stat      (tx_stat)
    );

    // live status
    always_comb begin
        status_word = '0;
        if (tx_stat.full)   status_word = status_word | ST_TX_FULL;
        if (tx_stat.empty)  status_word = status_word | ST_TX_EMPTY;
        if (rx_stat.full)   status_word = status_word | ST_RX_FULL;
        if (!rx_stat.empty) status_word = status_word | ST_RX_VALID;
    end

    // register updates
    always_comb begin
        rx_hold_next      = rx_hold_reg;
        tx_hold_next      = tx_hold_reg;
        control_word_next = control_word_reg;
        ack_wait_next     = ack_wait_reg;

        if (rx_ctrl.pop) begin
            rx_hold_next = rx_head_byte;
        end
        if (is_write) begin
            case (s_req.reg_sel)
                REG_RX_DATA: rx_hold_next      = s_req.write_data[7:0];
                REG_TX_DATA: tx_hold_next      = s_req.write_data;
                REG_CONTROL: control_word_next = s_req.write_data;
                default:     ;
            endcase
        end
        if (is_read) begin
            ack_wait_next = 1'b0;
        end else if (tx_ctrl.pop && tx_stat.one_left) begin
            ack_wait_next = 1'b1;
        end
    end

    // result
    always_comb begin
        m_res_next = '0;
        if (is_read) begin
            case (s_req.reg_sel)
                REG_RX_DATA: m_res_next.read_data = {24'd0, rx_hold_next};
                REG_TX_DATA: m_res_next.read_data = tx_hold_reg;
                REG_STATUS:  m_res_next.read_data = status_word;
                REG_CONTROL: m_res_next.read_data = control_word_reg;
                default:     m_res_next.read_data = '0;
            endcase
        end
        if (tx_ctrl.pop) begin
            m_res_next.tx_byte  = tx_head_byte;
            m_res_next.tx_valid = 1'b1;
        end
        m_res_next.tx_pending = !tx_stat.empty_after;
        m_res_next.irq        = !rx_stat.empty_after || ack_wait_next;
    end

    // output register
    always_comb begin
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_reg      <= '0;
            tx_hold_reg      <= '0;
            control_word_reg <= '0;
            ack_wait_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            rx_hold_reg      <= rx_hold_next;
            tx_hold_reg      <= tx_hold_next;
            control_word_reg <= control_word_next;
            ack_wait_reg     <= ack_wait_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;
endmodule

>>> sv/uft_cell.sv
module uft_cell (
    input  logic       aclk,
    input  logic       shift,
    input  logic       load,
    input  logic [7:0] neighbor_byte,
    input  logic [7:0] load_byte,
    output logic [7:0] q
);
    logic [7:0] data_reg;
    logic [7:0] data_next;

    // a load wins; otherwise take the neighbor's byte on a pop
    always_comb begin
        if (load) begin
            data_next = load_byte;
        end else if (shift) begin
            data_next = neighbor_byte;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;
endmodule

>>> sv/uft_fifo.sv
module uft_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  uft_pkg::uft_fifo_ctrl_t ctrl,
    input  logic [7:0]            din,
    output logic [7:0]            head_byte,
    output uft_pkg::uft_fifo_stat_t stat
);
    import uft_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       cell_q [FIFO_DEPTH];
    logic             do_push;
    logic             do_pop;

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign stat.one_left = (count_reg == CNT_W'(1));

    assign do_push = ctrl.push && !stat.full;
    assign do_pop  = ctrl.pop && !stat.empty;

    // fill count: flush, push and pop never come from the same request
    always_comb begin
        if (ctrl.flush) begin
            count_next = '0;
        end else if (do_push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    assign stat.empty_after = (count_next == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // chain of cells, head at cell 0; a pop moves every byte one cell down
    for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
        logic [7:0] nb;
        if (i == FIFO_DEPTH - 1) begin : g_last
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_q[i+1];
        end

        uft_cell u_cell (
            .aclk          (aclk),
            .shift         (do_pop),
            .load          (do_push && (count_reg == CNT_W'(i))),
            .neighbor_byte (nb),
            .load_byte     (din),
            .q             (cell_q[i])
        );
    end

    assign head_byte = cell_q[0];
endmodule

>>> tb/tb_uart_fifo_register_device.sv
`timescale 1ns / 1ps

module tb_uart_fifo_register_device;
    import uft_pkg::*;

    localparam int N_REQUESTS   = 950;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int N_DIRECTED   = 24;

    typedef struct {
        uft_req_t    req;
        bit          pinned;
        logic [31:0] pin_rd;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    uft_req_t s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    uft_res_t m_res;

    // hand-typed expectation that travels with the request
    bit          s_pinned = 1'b0;
    logic [31:0] s_pin_rd = '0;

    uart_fifo_register_device dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the UART register state
    // ------------------------------------------------------------------
    logic [7:0]  rx_mem [FIFO_DEPTH];
    logic [7:0]  tx_mem [FIFO_DEPTH];
    int unsigned rx_cnt = 0, rx_hd = 0;
    int unsigned tx_cnt = 0, tx_hd = 0;
    logic [7:0]  rx_hold_sh = '0;
    logic [31:0] tx_hold_sh = '0;
    logic [31:0] ctrl_sh = '0;
    bit          ack_wait_sh = 1'b0;

    int unsigned rx_drop_cnt = 0, tx_drop_cnt = 0, ack_set_cnt = 0;
    int unsigned sent_cnt = 0, res_cnt = 0, fault_cnt = 0;

    uft_res_t uart_expect_q [$];

    // Advance the shadow state by one request and return the result it gives
    function automatic uft_res_t uart_register_step(input uft_req_t r);
        uft_res_t o;
        o = '0;
        case (r.func)
            FN_BUS_READ: begin
                case (r.reg_sel)
                    REG_RX_DATA: begin
                        if (rx_cnt != 0) begin
                            rx_hold_sh = rx_mem[rx_hd];
                            rx_hd = (rx_hd + 1) % FIFO_DEPTH;
                            rx_cnt--;
                        end
                        o.read_data = {24'd0, rx_hold_sh};
                    end
                    REG_TX_DATA: o.read_data = tx_hold_sh;
                    REG_STATUS: begin
                        if (tx_cnt >= FIFO_DEPTH) o.read_data |= ST_TX_FULL;
                        if (tx_cnt == 0)          o.read_data |= ST_TX_EMPTY;
                        if (rx_cnt >= FIFO_DEPTH) o.read_data |= ST_RX_FULL;
                        if (rx_cnt != 0)          o.read_data |= ST_RX_VALID;
                    end
                    default: o.read_data = ctrl_sh;
                endcase
                ack_wait_sh = 1'b0;
            end
            FN_BUS_WRITE: begin
                case (r.reg_sel)
                    REG_RX_DATA: rx_hold_sh = r.write_data[7:0];
                    REG_TX_DATA: begin
                        tx_hold_sh = r.write_data;
                        if (tx_cnt < FIFO_DEPTH) begin
                            tx_mem[(tx_hd + tx_cnt) % FIFO_DEPTH] = r.write_data[7:0];
                            tx_cnt++;
                        end else begin
                            tx_drop_cnt++;
                        end
                    end
                    REG_CONTROL: begin
                        ctrl_sh = r.write_data;
                        if (r.write_data[CTL_FLUSH_TX]) tx_cnt = 0;
                        if (r.write_data[CTL_FLUSH_RX]) rx_cnt = 0;
                    end
                    default: ; // status is read-only
                endcase
            end
            FN_LINE_RX: begin
                if (rx_cnt < FIFO_DEPTH) begin
                    rx_mem[(rx_hd + rx_cnt) % FIFO_DEPTH] = r.rx_byte;
                    rx_cnt++;
                end else begin
                    rx_drop_cnt++;
                end
            end
            default: begin
                if (tx_cnt != 0) begin
                    o.tx_byte  = tx_mem[tx_hd];
                    o.tx_valid = 1'b1;
                    tx_hd = (tx_hd + 1) % FIFO_DEPTH;
                    tx_cnt--;
                    if (tx_cnt == 0) begin
                        ack_wait_sh = 1'b1;
                        ack_set_cnt++;
                    end
                end
            end
        endcase
        o.tx_pending = (tx_cnt != 0);
        o.irq        = (rx_cnt != 0) || ack_wait_sh;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: check results first, then log the newly taken request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        uft_res_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                res_cnt++;
                if (uart_expect_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("ERROR: result with nothing expected: rd=%h tb=%h tv=%b tp=%b irq=%b",
                                 m_res.read_data, m_res.tx_byte, m_res.tx_valid,
                                 m_res.tx_pending, m_res.irq);
                end else begin
                    want = uart_expect_q.pop_front();
                    if (m_res.read_data !== want.read_data || m_res.tx_byte !== want.tx_byte ||
                        m_res.tx_valid !== want.tx_valid ||
                        m_res.tx_pending !== want.tx_pending || m_res.irq !== want.irq) begin
                        fault_cnt++;
                        if (fault_cnt <= 10)
                            $display("ERROR: result %0d exp rd=%h tb=%h tv=%b tp=%b irq=%b, got rd=%h tb=%h tv=%b tp=%b irq=%b",
                                     res_cnt, want.read_data, want.tx_byte, want.tx_valid,
                                     want.tx_pending, want.irq, m_res.read_data,
                                     m_res.tx_byte, m_res.tx_valid, m_res.tx_pending,
                                     m_res.irq);
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = uart_register_step(s_req);
                if (s_pinned) begin
                    want = '0;
                    want.read_data = s_pin_rd;
                end
                uart_expect_q.push_back(want);
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge aclk) begin : watchdog
        int unsigned quiet;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: own stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned phase_left, style, tick;
        bit          held;
        phase_left = 0;
        style = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && res_cnt >= 300) begin
                // back up the block so it has to stall its input
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (phase_left == 0) begin
                    style = $urandom_range(0, 2);
                    phase_left = $urandom_range(10, 60);
                end
                phase_left--;
                tick++;
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 9) < 6);
                    default: m_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;

    task automatic send_request(input uft_req_t r, input bit pinned, input logic [31:0] pin_rd);
        int unsigned gap;
        s_req    <= r;
        s_pinned <= pinned;
        s_pin_rd <= pin_rd;
        s_valid  <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
        end
    endtask

    function automatic uft_req_t mk_req(input logic [1:0] fn, input logic [1:0] sel,
                                        input logic [31:0] wd, input logic [7:0] rb);
        uft_req_t r;
        r.func       = fn;
        r.reg_sel    = sel;
        r.write_data = wd;
        r.rx_byte    = rb;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] fn, input logic [1:0] sel,
                                        input logic [31:0] wd, input logic [7:0] rb,
                                        input bit pinned, input logic [31:0] rd);
        dir_row_t row;
        row.req    = mk_req(fn, sel, wd, rb);
        row.pinned = pinned;
        row.pin_rd = rd;
        return row;
    endfunction

    function automatic uft_req_t rand_req(input logic [1:0] fn, input logic [1:0] sel);
        return mk_req(fn, sel, $urandom, 8'($urandom_range(0, 255)));
    endfunction

    dir_row_t dir_tab [N_DIRECTED];

    initial begin : stimulus
        int unsigned pick, n;
        logic [31:0] ctl_word;

        // directed: reset values, hold registers, flush, ack wait
        dir_tab = '{
            mk_row(FN_BUS_READ,  REG_STATUS,  32'h0,         8'h00, 1, ST_TX_EMPTY),
            mk_row(FN_BUS_READ,  REG_RX_DATA, 32'h0,         8'h00, 1, 32'h0),
            mk_row(FN_TX_DRAIN,  REG_RX_DATA, 32'h0,         8'h00, 1, 32'h0),
            mk_row(FN_BUS_WRITE, REG_STATUS,  32'hffff_ffff, 8'hff, 1, 32'h0),
            mk_row(FN_BUS_WRITE, REG_RX_DATA, 32'hffff_ff5a, 8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_RX_DATA, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_TX_DATA, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_WRITE, REG_TX_DATA, 32'hffff_ffff, 8'h00, 0, 32'h0),
            mk_row(FN_BUS_WRITE, REG_TX_DATA, 32'h0000_0000, 8'hff, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_TX_DATA, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_WRITE, REG_CONTROL, 32'hffff_fffc, 8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_CONTROL, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_LINE_RX,   REG_TX_DATA, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_LINE_RX,   REG_CONTROL, 32'hffff_ffff, 8'hff, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_STATUS,  32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_RX_DATA, 32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_TX_DRAIN,  REG_STATUS,  32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_TX_DRAIN,  REG_STATUS,  32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_TX_DRAIN,  REG_STATUS,  32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_STATUS,  32'h0,         8'h00, 0, 32'h0),
            mk_row(FN_BUS_WRITE, REG_CONTROL, 32'h0000_0003, 8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_STATUS,  32'h0,         8'h00, 1, ST_TX_EMPTY),
            mk_row(FN_BUS_WRITE, REG_CONTROL, 32'h0000_0000, 8'h00, 0, 32'h0),
            mk_row(FN_BUS_READ,  REG_CONTROL, 32'h0,         8'h00, 1, 32'h0)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(dir_tab[i].req, dir_tab[i].pinned, dir_tab[i].pin_rd);

        // random: mostly fill/empty runs so both FIFOs hit full and empty
        while (sent_cnt < N_REQUESTS) begin
            pick = $urandom_range(0, 9);
            n = $urandom_range(8, 20);
            case (pick)
                0, 1: begin
                    repeat (n) send_request(rand_req(FN_LINE_RX, 2'($urandom)), 0, '0);
                    send_request(rand_req(FN_BUS_READ, REG_STATUS), 0, '0);
                end
                2: repeat (n) send_request(rand_req(FN_BUS_READ, REG_RX_DATA), 0, '0);
                3: begin
                    repeat (n) send_request(rand_req(FN_BUS_WRITE, REG_TX_DATA), 0, '0);
                    send_request(rand_req(FN_BUS_READ, REG_STATUS), 0, '0);
                end
                4: begin
                    repeat (n) send_request(rand_req(FN_TX_DRAIN, 2'($urandom)), 0, '0);
                    send_request(rand_req(FN_BUS_READ, 2'($urandom)), 0, '0);
                end
                5: repeat (n / 4) send_request(rand_req(FN_BUS_READ, 2'($urandom)), 0, '0);
                6: begin
                    // control write, flush bits picked on their own
                    ctl_word = $urandom;
                    ctl_word[CTL_FLUSH_TX] = ($urandom_range(0, 2) == 0);
                    ctl_word[CTL_FLUSH_RX] = ($urandom_range(0, 2) == 0);
                    send_request(mk_req(FN_BUS_WRITE, REG_CONTROL, ctl_word, 8'($urandom)),
                                 0, '0);
                    send_request(rand_req(FN_BUS_READ, REG_CONTROL), 0, '0);
                end
                default:
                    repeat (n) send_request(rand_req(2'($urandom), 2'($urandom)), 0, '0);
            endcase
        end

        // let every outstanding result come back
        s_valid <= 1'b0;
        while (uart_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d requests, %0d results checked, %0d errors",
                 sent_cnt, res_cnt, fault_cnt);
        $display("tb: %0d rx and %0d tx bytes dropped on full FIFOs, %0d ack-wait sets",
                 rx_drop_cnt, tx_drop_cnt, ack_set_cnt);
        if (fault_cnt == 0 && uart_expect_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
sv/uft_pkg.sv
sv/uft_cell.sv
sv/uft_fifo.sv
sv/uart_fifo_register_device.sv
tb/tb_uart_fifo_register_device.sv
